### design/pbjson_pkg.sv
`default_nettype none
package pbjson_pkg;

  // field widths
  localparam int KIND_W   = 4;
  localparam int VALUE_W  = 64;
  localparam int CHAR_W   = 8;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 8;

  // decimal converter sizing: 2^64 needs twenty digits
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int STEP_BITS  = 2;
  localparam int NUM_STEPS  = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(NUM_STEPS);
  localparam int POS_W      = 5;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(NUM_STEPS - 1);

  // ascii characters
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  typedef enum logic [KIND_W-1:0] {
    KIND_INT32   = 4'd0,
    KIND_UINT32  = 4'd1,
    KIND_SINT32  = 4'd2,
    KIND_INT64   = 4'd3,
    KIND_UINT64  = 4'd4,
    KIND_SINT64  = 4'd5,
    KIND_BOOL    = 4'd6,
    KIND_FIXED32 = 4'd7,
    KIND_FIXED64 = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  // how the current scalar is to be printed
  typedef struct packed {
    logic             is_bool;
    logic             bool_val;
    logic             quoted;
    logic             neg;
    logic [POS_W-1:0] ndig;
  } fmt_t;

  // converter status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  // characters of the literals true and false
  function automatic logic [CHAR_W-1:0] bool_char(input logic val, input logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    c = 8'h00;
    if (val) begin
      unique case (idx)
        3'd0: c = "t";
        3'd1: c = "r";
        3'd2: c = "u";
        3'd3: c = "e";
        default: c = 8'h00;
      endcase
    end else begin
      unique case (idx)
        3'd0: c = "f";
        3'd1: c = "a";
        3'd2: c = "l";
        3'd3: c = "s";
        3'd4: c = "e";
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### design/pbjson_bcd_unit.sv
`default_nettype none
module pbjson_bcd_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [pbjson_pkg::VALUE_W-1:0] mag,
  output pbjson_pkg::digits_t            digits,
  output pbjson_pkg::conv_stat_t         stat
);
  import pbjson_pkg::*;

  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_next;
  logic [VALUE_W-1:0]    bin;
  logic [VALUE_W-1:0]    bin_next;
  logic [STEP_CNT_W-1:0] cnt;
  logic                  busy;

  // shift-and-add-three, two bits per step
  always_comb begin
    bcd_next = bcd;
    bin_next = bin;
    for (int st = 0; st < STEP_BITS; st++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_next[DIGIT_W*d +: DIGIT_W] > 4'd4) begin
          bcd_next[DIGIT_W*d +: DIGIT_W] = bcd_next[DIGIT_W*d +: DIGIT_W] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BCD_W-2:0], bin_next[VALUE_W-1]};
      bin_next = {bin_next[VALUE_W-2:0], 1'b0};
    end
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (busy) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end
  end

  assign digits    = digits_t'(bcd);
  assign stat.busy = busy;
  assign stat.done = busy && (cnt == LAST_STEP);

endmodule
`default_nettype wire

### design/pbjson_char_gen.sv
`default_nettype none
module pbjson_char_gen (
  input  wire pbjson_pkg::fmt_t           fmt,
  input  wire logic [pbjson_pkg::POS_W-1:0] pos,
  input  wire pbjson_pkg::digits_t        digits,
  output logic [pbjson_pkg::CHAR_W-1:0]   ch,
  output logic                            last
);
  import pbjson_pkg::*;

  logic [POS_W-1:0]   len;
  logic [POS_W-1:0]   off;
  logic [POS_W-1:0]   didx;
  logic [DIGIT_W-1:0] dig;

  // text length: quotes, sign and digits, or the bool literal
  always_comb begin
    if (fmt.is_bool) begin
      len = fmt.bool_val ? 5'd4 : 5'd5;
    end else begin
      len = fmt.ndig + {4'd0, fmt.quoted} + {4'd0, fmt.quoted} + {4'd0, fmt.neg};
    end
  end

  // digit under the cursor, most significant first
  assign off  = pos - {4'd0, fmt.quoted} - {4'd0, fmt.neg};
  assign didx = fmt.ndig - 5'd1 - off;
  assign dig  = digits[didx];

  // character select
  always_comb begin
    if (fmt.is_bool) begin
      ch = bool_char(fmt.bool_val, pos[2:0]);
    end else if (fmt.quoted && (pos == '0 || pos == len - 5'd1)) begin
      ch = CH_QUOTE;
    end else if (fmt.neg && (pos == {4'd0, fmt.quoted})) begin
      ch = CH_MINUS;
    end else begin
      ch = CH_ZERO | {4'd0, dig};
    end
  end

  assign last = (pos == len - 5'd1);

endmodule
`default_nettype wire

### design/protobuf_scalar_json_formatter_core.sv
`default_nettype none
// channel  | direction | tdata fields (low bit up)        | tuser | tlast
// s_axis   | in        | kind[3:0], raw_value[67:4], pad  | -     | -
// m_axis   | out       | text_char[7:0]                   | -     | last_char
//
// one scalar at a time: s_tready is high only while idle
// decimal kinds pass through accept, 32 conversion steps (two bits per
// step through the shared add-three/shift unit) and a digit scan, then emit
// one character per cycle while m_tready is high; bool skips conversion and scan
// unused kind codes are taken and dropped without output
// rst is synchronous; output stalls hold the character until m_tready
module protobuf_scalar_json_formatter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [pbjson_pkg::S_DATA_W-1:0] s_tdata,  // kind[3:0], raw_value[67:4]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [pbjson_pkg::M_DATA_W-1:0]    m_tdata,   // text_char[7:0]
  output logic                               m_tlast
);
  import pbjson_pkg::*;

  state_t             state;
  state_t             state_next;
  fmt_t               fmt;
  fmt_t               fmt_next;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_next;

  kind_t              kind;
  logic [VALUE_W-1:0] raw;
  logic [31:0]        val32;
  logic [31:0]        mag32;
  logic [VALUE_W-1:0] val64;
  logic [VALUE_W-1:0] mag64;
  logic               neg32;
  logic               neg64;
  logic               is32;
  logic               is_signed32;
  logic               is_signed64;
  logic               known;
  logic [VALUE_W-1:0] mag;
  logic               in_xfer;
  logic               out_xfer;
  logic               conv_start;
  logic [POS_W-1:0]   ndig_scan;
  logic [CHAR_W-1:0]  ch;
  logic               last;
  digits_t            digits;
  conv_stat_t         cstat;

  assign kind     = kind_t'(s_tdata[KIND_W-1:0]);
  assign raw      = s_tdata[KIND_W +: VALUE_W];
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // kind decode
  always_comb begin
    is32        = 1'b0;
    is_signed32 = 1'b0;
    is_signed64 = 1'b0;
    known       = 1'b1;
    unique case (kind)
      KIND_INT32:   begin is32 = 1'b1; is_signed32 = 1'b1; end
      KIND_UINT32:  is32 = 1'b1;
      KIND_SINT32:  begin is32 = 1'b1; is_signed32 = 1'b1; end
      KIND_INT64:   is_signed64 = 1'b1;
      KIND_UINT64:  ;
      KIND_SINT64:  is_signed64 = 1'b1;
      KIND_BOOL:    ;
      KIND_FIXED32: is32 = 1'b1;
      KIND_FIXED64: ;
      default:      known = 1'b0;
    endcase
  end

  // zigzag decode and magnitude
  always_comb begin
    val32 = (kind == KIND_SINT32) ? ({1'b0, raw[31:1]} ^ {32{raw[0]}}) : raw[31:0];
    neg32 = is_signed32 && val32[31];
    mag32 = neg32 ? (32'd0 - val32) : val32;
    val64 = (kind == KIND_SINT64) ? ({1'b0, raw[VALUE_W-1:1]} ^ {VALUE_W{raw[0]}}) : raw;
    neg64 = is_signed64 && val64[VALUE_W-1];
    mag64 = neg64 ? (64'd0 - val64) : val64;
    mag   = is32 ? {32'd0, mag32} : mag64;
  end

  // top nonzero digit gives the digit count
  always_comb begin
    ndig_scan = 5'd1;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (digits[d] != '0) ndig_scan = POS_W'(d + 1);
    end
  end

  pbjson_bcd_unit u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .mag    (mag),
    .digits (digits),
    .stat   (cstat)
  );

  pbjson_char_gen u_chr (
    .fmt    (fmt),
    .pos    (pos),
    .digits (digits),
    .ch     (ch),
    .last   (last)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && known) begin
          state_next = (kind == KIND_BOOL) ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: if (cstat.done) state_next = ST_SCAN;
      ST_SCAN: state_next = ST_EMIT;
      ST_EMIT: if (out_xfer && last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_tready   = (state == ST_IDLE);
    m_tvalid   = (state == ST_EMIT);
    conv_start = 1'b0;
    fmt_next   = fmt;
    pos_next   = pos;
    unique case (state)
      ST_IDLE: begin
        pos_next = '0;
        if (in_xfer) begin
          conv_start        = known && (kind != KIND_BOOL);
          fmt_next.is_bool  = (kind == KIND_BOOL);
          fmt_next.bool_val = (raw != '0);
          fmt_next.quoted   = !is32;
          fmt_next.neg      = is32 ? neg32 : neg64;
          fmt_next.ndig     = 5'd1;
        end
      end
      ST_CONV: ;
      ST_SCAN: fmt_next.ndig = ndig_scan;
      ST_EMIT: if (out_xfer) pos_next = pos + 5'd1;
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    fmt <= fmt_next;
  end

  assign m_tdata = ch;
  assign m_tlast = last;

  // one scalar at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while output active");

  // final character returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not idle after final character");

  // converter only runs during conversion
  a_conv_busy: assert property (@(posedge clk) disable iff (rst)
    cstat.busy |-> (state == ST_CONV))
    else $error("converter busy outside conversion");

endmodule
`default_nettype wire

### tb/pbjson_text_checker.sv
module pbjson_text_checker
  import pbjson_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // kind[3:0], raw_value[67:4], pad
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,   // text_char[7:0]
  input  logic                m_tlast,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } json_char_t;

  // characters still owed by the block, oldest first
  json_char_t json_text_q[$];

  // work out the json text of one scalar and queue its characters
  function automatic void queue_json_text(input logic [KIND_W-1:0] kind,
                                          input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] zz;
    logic [31:0]        lo;
    logic               neg;
    logic               quoted;
    logic               is_num;
    logic [CHAR_W-1:0]  digits[NUM_DIGITS];
    logic [CHAR_W-1:0]  txt[NUM_DIGITS+4];
    string              lit;
    int                 nd;
    int                 n;
    json_char_t         c;
    lo     = raw[31:0];
    neg    = 1'b0;
    quoted = 1'b0;
    is_num = 1'b1;
    mag    = '0;
    nd     = 0;
    n      = 0;
    case (kind)
      KIND_INT32, KIND_SINT32: begin
        // zigzag decode on 32 bits for sint32, then two's complement magnitude
        if (kind == KIND_SINT32) lo = (lo >> 1) ^ {32{lo[0]}};
        neg = lo[31];
        mag = {32'h0, (neg ? (~lo + 32'd1) : lo)};
      end
      KIND_UINT32, KIND_FIXED32: mag = {32'h0, lo};
      KIND_INT64: begin
        quoted = 1'b1;
        neg    = raw[63];
        mag    = neg ? (~raw + 64'd1) : raw;
      end
      KIND_UINT64, KIND_FIXED64: begin
        quoted = 1'b1;
        mag    = raw;
      end
      KIND_SINT64: begin
        zz     = (raw >> 1) ^ {VALUE_W{raw[0]}};
        quoted = 1'b1;
        neg    = zz[63];
        mag    = neg ? (~zz + 64'd1) : zz;
      end
      KIND_BOOL: begin
        is_num = 1'b0;
        if (raw != '0) lit = "true";
        else lit = "false";
        for (int i = 0; i < lit.len(); i++) begin
          txt[n] = lit[i];
          n++;
        end
      end
      // unused codes are dropped silently
      default: return;
    endcase
    if (is_num) begin
      // digits come out least significant first
      do begin
        digits[nd] = CH_ZERO + CHAR_W'(mag % 64'd10);
        mag        = mag / 64'd10;
        nd++;
      end while (mag != '0);
      if (quoted) begin
        txt[n] = CH_QUOTE;
        n++;
      end
      if (neg) begin
        txt[n] = CH_MINUS;
        n++;
      end
      while (nd > 0) begin
        nd--;
        txt[n] = digits[nd];
        n++;
      end
      if (quoted) begin
        txt[n] = CH_QUOTE;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      c.text_char = txt[i];
      c.last_char = (i == n - 1);
      json_text_q.insert(json_text_q.size(), c);
    end
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    json_char_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        queue_json_text(s_tdata[KIND_W-1:0], s_tdata[KIND_W +: VALUE_W]);
      if (m_tvalid && m_tready) begin
        if (json_text_q.size() == 0) begin
          $error("unexpected transfer: text_char %h last_char %b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = json_text_q.pop_front();
          if (m_tdata !== want.text_char) begin
            $error("text_char expected %h actual %h", want.text_char, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.last_char) begin
            $error("last_char expected %b actual %b", want.last_char, m_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = json_text_q.size();
  end

endmodule

### tb/protobuf_scalar_json_formatter_core_tb.sv
module protobuf_scalar_json_formatter_core_tb;
  import pbjson_pkg::*;

  localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 4'd9;
  localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 4'd15;
  localparam int RANDOM_PER_PHASE = 97;
  localparam int DRAIN_CYCLES     = 100;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // kind[3:0], raw_value[67:4], pad
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // text_char[7:0]
  logic                m_tlast;

  int fail_count;
  int pending;
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  protobuf_scalar_json_formatter_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  pbjson_text_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // output back-pressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // run limit
  initial begin
    #(12 * 400000);
    $display("protobuf_scalar_json_formatter_core_tb NOT OK");
    $finish;
  end

  // offer one scalar, optionally after an idle gap, and hold it until taken
  task automatic send_scalar(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] raw);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(60, 5) : $urandom_range(4, 1);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(S_DATA_W - KIND_W - VALUE_W){1'b0}}, raw, kind};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // values biased towards digit-count edges, signs and extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    logic [31:0]        p32;
    p   = 64'd1;
    p32 = 32'd1;
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return VALUE_W'($urandom_range(20));
      2: return ~VALUE_W'($urandom_range(20));
      3: begin
        repeat ($urandom_range(19)) p = p * 64'd10;
        return p + VALUE_W'($urandom_range(2)) - 64'd1;
      end
      4: begin
        repeat ($urandom_range(9)) p32 = p32 * 32'd10;
        return {$urandom, p32 + 32'($urandom_range(2)) - 32'd1};
      end
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [KIND_W-1:0]  kind;
    int                 counted;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: extremes, ignored high bits, bool literals, unused codes
    send_scalar(KIND_INT32,   64'h0000_0000_0000_0000);
    send_scalar(KIND_INT32,   64'h0000_0000_7FFF_FFFF);
    send_scalar(KIND_INT32,   64'h0000_0000_8000_0000);
    send_scalar(KIND_INT32,   64'hFFFF_FFFF_FFFF_FFFF);
    send_scalar(KIND_INT32,   64'hDEAD_BEEF_0000_0005);
    send_scalar(KIND_UINT32,  64'h0000_0000_FFFF_FFFF);
    send_scalar(KIND_UINT32,  64'hFFFF_FFFF_0000_0000);
    send_scalar(KIND_SINT32,  64'h0000_0000_FFFF_FFFF);
    send_scalar(KIND_SINT32,  64'h0000_0000_FFFF_FFFE);
    send_scalar(KIND_SINT32,  64'hA5A5_A5A5_0000_0001);
    send_scalar(KIND_INT64,   64'h8000_0000_0000_0000);
    send_scalar(KIND_INT64,   64'h7FFF_FFFF_FFFF_FFFF);
    send_scalar(KIND_INT64,   64'hFFFF_FFFF_FFFF_FFFF);
    send_scalar(KIND_UINT64,  64'hFFFF_FFFF_FFFF_FFFF);
    send_scalar(KIND_UINT64,  64'h0000_0000_0000_0000);
    send_scalar(KIND_SINT64,  64'hFFFF_FFFF_FFFF_FFFF);
    send_scalar(KIND_SINT64,  64'hFFFF_FFFF_FFFF_FFFE);
    send_scalar(KIND_SINT64,  64'h0000_0000_0000_0000);
    send_scalar(KIND_BOOL,    64'h0000_0000_0000_0000);
    send_scalar(KIND_BOOL,    64'h0000_0000_0000_0001);
    send_scalar(KIND_BOOL,    64'h8000_0000_0000_0000);
    send_scalar(KIND_FIXED32, 64'h1234_5678_FFFF_FFFF);
    send_scalar(KIND_FIXED64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_scalar(KIND_FIXED64, 64'h0000_0000_0000_000A);
    send_scalar(KIND_FIRST_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_scalar(KIND_LAST_UNUSED,  64'h0000_0000_0000_0001);

    // random phases: free flow, idle sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 65;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 65;
        end
        default: begin
          src_idle_pct   = 9;
          sink_stall_pct = 9;
        end
      endcase
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        if ($urandom_range(99) < 8)
          kind = KIND_W'($urandom_range(KIND_LAST_UNUSED, KIND_FIRST_UNUSED));
        else
          kind = KIND_W'($urandom_range(KIND_FIXED64, KIND_INT32));
        send_scalar(kind, pick_value());
        counted++;
      end
      // hold off until every owed character has arrived
      s_tvalid = 1'b0;
      while (pending != 0) @(negedge clk);
    end

    // let any late activity show up, then give the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("protobuf_scalar_json_formatter_core_tb OK");
    end else begin
      $display("protobuf_scalar_json_formatter_core_tb NOT OK");
    end
    $finish;
  end

endmodule
